### design/fscs_pkg.sv
package fscs_pkg;

    localparam int SLOTS = 32;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_LOOKUP = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_EXPAND = 3'd3;
    localparam logic [2:0] MODE_REDUCE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_LARGE   = 2'd3;

    localparam logic [31:0] CAP_RESET = 32'd1048576;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] video_id;
        logic [15:0] segment_number;
        logic [23:0] item_size;
        logic [23:0] capacity_delta;
    } cmd_t;

    typedef struct packed {
        logic        is_eviction;
        logic [31:0] evicted_video_id;
        logic [15:0] evicted_segment_number;
        logic [1:0]  status;
        logic [31:0] used_size;
        logic        last;
    } result_t;

    // key search request and answer between sequencer and search unit
    typedef struct packed {
        logic        start;
        logic [31:0] video_id;
        logic [15:0] segment_number;
    } srch_req_t;

    typedef struct packed {
        logic          done;
        logic          found;
        logic [SW-1:0] slot;
    } srch_rsp_t;

endpackage

### design/fscs_search.sv
module fscs_search
    import fscs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srch_req_t            req,
    input  logic [SLOTS-1:0]     valid,
    input  logic [31:0]          rd_vid,
    input  logic [15:0]          rd_seg,
    output logic [SW-1:0]        rd_addr,
    output srch_rsp_t            rsp
);

    logic          run_reg, run_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] chk_reg, chk_next;
    logic          pend_reg, pend_next;
    logic [31:0]   vid_reg;
    logic [15:0]   seg_reg;
    logic          hit;

    // memory read address is the scan index; the store read data comes back registered
    assign rd_addr = idx_reg[SW-1:0];
    assign hit = pend_reg && valid[chk_reg[SW-1:0]] &&
                 rd_vid == vid_reg && rd_seg == seg_reg;

    always_comb
    begin
        run_next  = run_reg;
        idx_next  = idx_reg;
        chk_next  = idx_reg;
        pend_next = 1'b0;
        rsp.done  = 1'b0;
        rsp.found = 1'b0;
        rsp.slot  = chk_reg[SW-1:0];
        if (req.start)
        begin
            run_next = 1'b1;
            idx_next = '0;
        end
        else if (run_reg)
        begin
            if (hit)
            begin
                rsp.done  = 1'b1;
                rsp.found = 1'b1;
                run_next  = 1'b0;
            end
            else if (idx_reg == CW'(SLOTS))
            begin
                if (!pend_reg)
                begin
                    rsp.done = 1'b1;
                    run_next = 1'b0;
                end
            end
            else
            begin
                pend_next = 1'b1;
                idx_next  = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            idx_reg  <= '0;
            chk_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            idx_reg  <= idx_next;
            chk_reg  <= chk_next;
            pend_reg <= pend_next && !req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            vid_reg <= req.video_id;
            seg_reg <= req.segment_number;
        end
    end

endmodule

### design/fifo_sized_cache_segment.sv
// channel   | ports                         | handshake
// ----------+-------------------------------+------------------------------
// command   | start, cmd                    | taken when start & !busy
// result    | result_valid, result          | one cycle strobe, no stall
// config    | cfg_we, cfg_data              | written when cfg_we high
//
// lookup, delete and insert scan the key store one slot a cycle through the
// search unit. An eviction runs S_EVCHK, S_EVRD, S_EVOUT, reading the oldest
// entry and moving the oldest pointer. expand runs S_DISP, S_FIN; reduce runs
// S_DISP, S_EVCHK and evictions, S_FIN. busy is high for the whole command.
// reset empties the cache and loads capacity with its reset value.
// results cannot be held off; each word is shown for one cycle only.
module fifo_sized_cache_segment
    import fscs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    output logic        result_valid,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_EVCHK  = 4'd3;
    localparam logic [3:0] S_EVRD   = 4'd4;
    localparam logic [3:0] S_EVOUT  = 4'd5;
    localparam logic [3:0] S_INS    = 4'd6;
    localparam logic [3:0] S_DELRD  = 4'd7;
    localparam logic [3:0] S_DELUPD = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    // slot store
    logic [31:0]   mem_vid [SLOTS];
    logic [15:0]   mem_seg [SLOTS];
    logic [23:0]   mem_size [SLOTS];
    logic [SW-1:0] mem_newer [SLOTS];
    logic [SW-1:0] mem_older [SLOTS];

    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SW-1:0]    oldest_reg, oldest_next;
    logic [SW-1:0]    newest_reg, newest_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [31:0]      used_reg, used_next;
    logic [31:0]      cap_reg, cap_next;
    logic [3:0]       state_reg, state_next;
    cmd_t             cmd_reg;
    logic [1:0]       st_reg, st_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [CW-1:0]    evn_reg, evn_next;

    logic [SW-1:0] rd_addr;
    logic [31:0]   rd_vid;
    logic [15:0]   rd_seg;
    logic [23:0]   rd_size;
    logic [SW-1:0] rd_newer, rd_older;
    logic [SW-1:0] seq_addr, srch_addr;

    // write ports: entry write, newer link write, older link write
    logic          we_ent;
    logic [SW-1:0] wa_ent;
    logic          we_nw;
    logic [SW-1:0] wa_nw, wd_nw;
    logic          we_ol;
    logic [SW-1:0] wa_ol, wd_ol;

    srch_req_t sreq;
    srch_rsp_t srsp;

    logic          res_v_next;
    result_t       res_next;
    result_t       res_reg;
    logic          resv_reg;
    logic [SW-1:0] free_slot;
    logic [32:0]   need;
    logic [32:0]   capsum;
    logic [31:0]   redcap;
    logic [31:0]   dsz;

    fscs_search u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sreq),
        .valid   (valid_reg),
        .rd_vid  (rd_vid),
        .rd_seg  (rd_seg),
        .rd_addr (srch_addr),
        .rsp     (srsp)
    );

    assign rd_addr = (state_reg == S_SRCH) ? srch_addr : seq_addr;

    // store reads registered, writes on clock
    always_ff @(posedge clk)
    begin
        rd_vid   <= mem_vid[rd_addr];
        rd_seg   <= mem_seg[rd_addr];
        rd_size  <= mem_size[rd_addr];
        rd_newer <= mem_newer[rd_addr];
        rd_older <= mem_older[rd_addr];
        if (we_ent)
        begin
            mem_vid[wa_ent]  <= cmd_reg.video_id;
            mem_seg[wa_ent]  <= cmd_reg.segment_number;
            mem_size[wa_ent] <= cmd_reg.item_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_nw)
            mem_newer[wa_nw] <= wd_nw;
    end

    always_ff @(posedge clk)
    begin
        if (we_ol)
            mem_older[wa_ol] <= wd_ol;
    end

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!valid_reg[i])
                free_slot = SW'(i);
    end

    assign need   = {1'b0, used_reg} + {9'd0, cmd_reg.item_size};
    assign capsum = {1'b0, cap_reg} + {9'd0, cmd_reg.capacity_delta};
    assign redcap = ({8'd0, cmd_reg.capacity_delta} >= cap_reg) ? 32'd0 :
                    cap_reg - {8'd0, cmd_reg.capacity_delta};
    assign dsz    = ({8'd0, rd_size} <= used_reg) ? {8'd0, rd_size} : used_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        count_next  = count_reg;
        used_next   = used_reg;
        cap_next    = cap_reg;
        st_next     = st_reg;
        slot_next   = slot_reg;
        evn_next    = evn_reg;
        seq_addr    = slot_reg;
        sreq.start  = 1'b0;
        sreq.video_id       = cmd_reg.video_id;
        sreq.segment_number = cmd_reg.segment_number;
        we_ent = 1'b0;
        wa_ent = free_slot;
        we_nw  = 1'b0;
        wa_nw  = '0;
        wd_nw  = '0;
        we_ol  = 1'b0;
        wa_ol  = '0;
        wd_ol  = '0;
        res_v_next = 1'b0;
        res_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    st_next  = ST_OK;
                    evn_next = '0;
                    state_next = S_DISP;
                    if (cmd.mode == MODE_INSERT || cmd.mode == MODE_LOOKUP ||
                        cmd.mode == MODE_DELETE)
                        state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (srsp.done)
                begin
                    slot_next = srsp.slot;
                    state_next = S_FIN;
                    case (cmd_reg.mode)
                        MODE_INSERT:
                        begin
                            if (srsp.found)
                                st_next = ST_PRESENT;
                            else if ({8'd0, cmd_reg.item_size} > cap_reg)
                                st_next = ST_LARGE;
                            else
                                state_next = S_EVCHK;
                        end
                        MODE_LOOKUP:
                            st_next = srsp.found ? ST_OK : ST_MISS;
                        default:
                        begin
                            if (srsp.found)
                                state_next = S_DELRD;
                            else
                                st_next = ST_MISS;
                        end
                    endcase
                end
            end
            S_DISP:
            begin
                state_next = S_FIN;
                if (cmd_reg.mode == MODE_EXPAND)
                    cap_next = capsum[32] ? 32'hFFFF_FFFF : capsum[31:0];
                else if (cmd_reg.mode == MODE_REDUCE)
                begin
                    cap_next = redcap;
                    state_next = S_EVCHK;
                end
            end
            S_EVCHK:
            begin
                // evict oldest while over capacity or slots full
                seq_addr = oldest_reg;
                slot_next = oldest_reg;
                if (count_reg != '0 && evn_reg != CW'(SLOTS) &&
                    ((cmd_reg.mode == MODE_INSERT &&
                      (need > {1'b0, cap_reg} || count_reg == CW'(SLOTS))) ||
                     (cmd_reg.mode == MODE_REDUCE && used_reg > cap_reg)))
                    state_next = S_EVRD;
                else if (cmd_reg.mode == MODE_INSERT)
                    state_next = S_INS;
                else
                    state_next = S_FIN;
            end
            S_EVRD:
            begin
                state_next = S_EVOUT;
            end
            S_EVOUT:
            begin
                valid_next[slot_reg] = 1'b0;
                count_next = count_reg - 1'b1;
                used_next  = used_reg - dsz;
                if (count_reg != CW'(1))
                    oldest_next = rd_newer;
                res_v_next = 1'b1;
                res_next.is_eviction = 1'b1;
                res_next.evicted_video_id = rd_vid;
                res_next.evicted_segment_number = rd_seg;
                res_next.used_size = used_reg - dsz;
                evn_next = evn_reg + 1'b1;
                state_next = S_EVCHK;
            end
            S_INS:
            begin
                we_ent = 1'b1;
                valid_next[free_slot] = 1'b1;
                if (count_reg == '0)
                    oldest_next = free_slot;
                else
                begin
                    we_nw = 1'b1;
                    wa_nw = newest_reg;
                    wd_nw = free_slot;
                    we_ol = 1'b1;
                    wa_ol = free_slot;
                    wd_ol = newest_reg;
                end
                newest_next = free_slot;
                count_next = count_reg + 1'b1;
                used_next  = used_reg + {8'd0, cmd_reg.item_size};
                state_next = S_FIN;
            end
            S_DELRD:
            begin
                state_next = S_DELUPD;
            end
            S_DELUPD:
            begin
                if (count_reg == CW'(1))
                begin
                end
                else if (slot_reg == oldest_reg)
                    oldest_next = rd_newer;
                else if (slot_reg == newest_reg)
                    newest_next = rd_older;
                else
                begin
                    we_nw = 1'b1;
                    wa_nw = rd_older;
                    wd_nw = rd_newer;
                    we_ol = 1'b1;
                    wa_ol = rd_newer;
                    wd_ol = rd_older;
                end
                valid_next[slot_reg] = 1'b0;
                count_next = count_reg - 1'b1;
                used_next  = used_reg - dsz;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                res_v_next = 1'b1;
                res_next.status = st_reg;
                res_next.used_size = used_reg;
                res_next.last = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && start &&
            (cmd.mode == MODE_INSERT || cmd.mode == MODE_LOOKUP ||
             cmd.mode == MODE_DELETE))
        begin
            sreq.start = 1'b1;
            sreq.video_id = cmd.video_id;
            sreq.segment_number = cmd.segment_number;
        end
        if (cfg_we)
            cap_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            oldest_reg <= '0;
            newest_reg <= '0;
            count_reg  <= '0;
            used_reg   <= '0;
            cap_reg    <= CAP_RESET;
            st_reg     <= ST_OK;
            evn_reg    <= '0;
            resv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            oldest_reg <= oldest_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
            used_reg   <= used_next;
            cap_reg    <= cap_next;
            st_reg     <= st_next;
            evn_reg    <= evn_next;
            resv_reg   <= res_v_next;
        end
    end

    // command and result words
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        res_reg  <= res_next;
        if (state_reg == S_IDLE && start)
            cmd_reg <= cmd;
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = resv_reg;
    assign result = res_reg;

endmodule

### dv/fifo_sized_cache_segment_tb.sv
`timescale 1ns / 100ps

module fifo_sized_cache_segment_tb;
    import fscs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic        clk;
    logic        rst_n;
    logic        start;
    cmd_t        cmd;
    logic        busy;
    logic        result_valid;
    result_t     result;
    logic        cfg_we;
    logic [31:0] cfg_data;

    fifo_sized_cache_segment u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // shadow copy of the cache
    logic          sh_valid [SLOTS];
    logic [31:0]   sh_vid   [SLOTS];
    logic [15:0]   sh_seg   [SLOTS];
    logic [23:0]   sh_size  [SLOTS];
    logic [SW-1:0] sh_newer [SLOTS];
    logic [SW-1:0] sh_older [SLOTS];
    logic [SW-1:0] sh_oldest;
    logic [SW-1:0] sh_newest;
    int            sh_count;
    logic [31:0]   sh_used;
    logic [31:0]   sh_cap;

    result_t expected_words [$];
    int      error_count;
    int      cmds_sent;
    int      words_seen;
    int      evictions_seen;
    int      idle_cycles;

    // stimulus table for the directed part
    typedef struct packed {
        cmd_t    c;
        logic    typed;
        result_t r;
    } dir_row_t;

    dir_row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void cache_reset();
        for (int i = 0; i < SLOTS; i++)
            sh_valid[i] = 1'b0;
        sh_oldest = '0;
        sh_newest = '0;
        sh_count  = 0;
        sh_used   = '0;
        sh_cap    = CAP_RESET;
    endfunction

    function automatic int find_entry(input logic [31:0] vid, input logic [15:0] seg);
        for (int i = 0; i < SLOTS; i++)
            if (sh_valid[i] && sh_vid[i] == vid && sh_seg[i] == seg)
                return i;
        return -1;
    endfunction

    function automatic void unlink_entry(input int s);
        logic [SW-1:0] o;
        logic [SW-1:0] n;
        if (!sh_valid[s] || sh_count == 0)
            return;
        if (sh_count == 1)
        begin
        end
        else if (s == sh_oldest)
            sh_oldest = sh_newer[s];
        else if (s == sh_newest)
            sh_newest = sh_older[s];
        else
        begin
            o = sh_older[s];
            n = sh_newer[s];
            sh_newer[o] = n;
            sh_older[n] = o;
        end
        sh_valid[s] = 1'b0;
        sh_count--;
        sh_used = sh_used - ((sh_size[s] <= sh_used) ? 32'(sh_size[s]) : sh_used);
    endfunction

    function automatic void push_word(input logic ev, input logic [31:0] vid,
                                      input logic [15:0] seg, input logic [1:0] st,
                                      input logic lst);
        result_t w;
        w.is_eviction            = ev;
        w.evicted_video_id       = vid;
        w.evicted_segment_number = seg;
        w.status                 = st;
        w.used_size              = sh_used;
        w.last                   = lst;
        expected_words = {expected_words, w};
    endfunction

    function automatic void evict_oldest_entry();
        int s;
        logic [31:0] vid;
        logic [15:0] seg;
        s   = sh_oldest;
        vid = sh_vid[s];
        seg = sh_seg[s];
        unlink_entry(s);
        push_word(1'b1, vid, seg, ST_OK, 1'b0);
    endfunction

    // predicts the words of one command and updates the shadow cache
    function automatic void predict_cache_words(input cmd_t c);
        logic [1:0]  st;
        int          k;
        int          s;
        logic [32:0] wide;
        logic [31:0] nc;
        st = ST_OK;
        k  = 0;
        case (c.mode)
            MODE_INSERT:
            begin
                if (find_entry(c.video_id, c.segment_number) >= 0)
                    st = ST_PRESENT;
                else if (32'(c.item_size) > sh_cap)
                    st = ST_LARGE;
                else
                begin
                    while (sh_count > 0 && k < SLOTS &&
                           ((33'(sh_used) + 33'(c.item_size) > 33'(sh_cap)) ||
                            sh_count >= SLOTS))
                    begin
                        evict_oldest_entry();
                        k++;
                    end
                    s = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!sh_valid[i])
                            s = i;
                    if (s >= 0)
                    begin
                        sh_valid[s] = 1'b1;
                        sh_vid[s]   = c.video_id;
                        sh_seg[s]   = c.segment_number;
                        sh_size[s]  = c.item_size;
                        if (sh_count == 0)
                            sh_oldest = SW'(s);
                        else
                        begin
                            sh_newer[sh_newest] = SW'(s);
                            sh_older[s] = sh_newest;
                        end
                        sh_newest = SW'(s);
                        sh_count++;
                        sh_used = sh_used + 32'(c.item_size);
                    end
                end
            end
            MODE_LOOKUP:
                st = (find_entry(c.video_id, c.segment_number) >= 0) ? ST_OK : ST_MISS;
            MODE_DELETE:
            begin
                s = find_entry(c.video_id, c.segment_number);
                if (s >= 0)
                    unlink_entry(s);
                else
                    st = ST_MISS;
            end
            MODE_EXPAND:
            begin
                wide   = 33'(sh_cap) + 33'(c.capacity_delta);
                sh_cap = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
            end
            MODE_REDUCE:
            begin
                nc = (32'(c.capacity_delta) >= sh_cap) ? 32'd0
                                                       : sh_cap - 32'(c.capacity_delta);
                while (sh_count > 0 && sh_used > nc && k < SLOTS)
                begin
                    evict_oldest_entry();
                    k++;
                end
                sh_cap = nc;
            end
            default:
            begin
            end
        endcase
        push_word(1'b0, '0, '0, st, 1'b1);
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            words_seen++;
            if (result.is_eviction)
                evictions_seen++;
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, used_size", 64'(result.used_size),
                                64'd0);
            else
            begin
                want = expected_words.pop_front();
                if (result.is_eviction !== want.is_eviction)
                    report_mismatch("is_eviction", 64'(result.is_eviction),
                                    64'(want.is_eviction));
                if (result.evicted_video_id !== want.evicted_video_id)
                    report_mismatch("evicted_video_id", 64'(result.evicted_video_id),
                                    64'(want.evicted_video_id));
                if (result.evicted_segment_number !== want.evicted_segment_number)
                    report_mismatch("evicted_segment_number",
                                    64'(result.evicted_segment_number),
                                    64'(want.evicted_segment_number));
                if (result.status !== want.status)
                    report_mismatch("status", 64'(result.status), 64'(want.status));
                if (result.used_size !== want.used_size)
                    report_mismatch("used_size", 64'(result.used_size),
                                    64'(want.used_size));
                if (result.last !== want.last)
                    report_mismatch("last", 64'(result.last), 64'(want.last));
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50)
            n = 0;
        else if (n < 92)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(10, 60);
        repeat (n) @(negedge clk);
    endtask

    // drives one command and waits for its acceptance
    task automatic send_command(input cmd_t c, input logic typed, input result_t r);
        start = 1'b1;
        cmd   = c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (typed)
        begin
            predict_cache_words(c);
            if (expected_words[$] != r)
                report_mismatch("directed row, used_size",
                                64'(expected_words[$].used_size), 64'(r.used_size));
        end
        else
            predict_cache_words(c);
        cmds_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    // waits until every word has come, then lets the block settle
    task automatic drain();
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sh_cap = v;
    endtask

    function automatic cmd_t make_cmd(input logic [2:0] m, input logic [31:0] vid,
                                      input logic [15:0] seg, input logic [23:0] sz,
                                      input logic [23:0] d);
        cmd_t c;
        c.mode           = m;
        c.video_id       = vid;
        c.segment_number = seg;
        c.item_size      = sz;
        c.capacity_delta = d;
        return c;
    endfunction

    function automatic result_t status_word(input logic [1:0] st, input logic [31:0] used);
        result_t w;
        w = '0;
        w.status    = st;
        w.used_size = used;
        w.last      = 1'b1;
        return w;
    endfunction

    function automatic void add_row(input cmd_t c, input logic typed, input result_t r);
        dir_row_t row;
        row.c     = c;
        row.typed = typed;
        row.r     = r;
        dir_rows = {dir_rows, row};
    endfunction

    // random command, keys drawn from a small pool so hits are common
    function automatic cmd_t random_cmd(input int phase);
        cmd_t c;
        int   p;
        c.video_id       = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 11));
        c.segment_number = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 3));
        c.item_size      = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(0, 40));
        c.capacity_delta = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(0, 60));
        p = $urandom_range(0, 99);
        if (p < 45)
            c.mode = MODE_INSERT;
        else if (p < 62)
            c.mode = MODE_LOOKUP;
        else if (p < 77)
            c.mode = MODE_DELETE;
        else if (p < 86)
            c.mode = MODE_EXPAND;
        else if (p < 96)
            c.mode = MODE_REDUCE;
        else
            c.mode = 3'($urandom_range(5, 7));
        if (phase == 3 && c.mode == MODE_INSERT)
            c.item_size = 24'($urandom_range(0, 3));
        return c;
    endfunction

    initial
    begin
        logic [31:0] caps [4];
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        error_count = 0;
        cmds_sent   = 0;
        words_seen  = 0;
        evictions_seen = 0;
        idle_cycles = 0;
        cache_reset();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (SLOTS * 2) @(negedge clk);

        // directed table
        add_row(make_cmd(MODE_LOOKUP, 32'd0, 16'd0, '0, '0), 1'b1, status_word(ST_MISS, 0));
        add_row(make_cmd(MODE_DELETE, '1, '1, '0, '0), 1'b1, status_word(ST_MISS, 0));
        add_row(make_cmd(MODE_INSERT, '1, '1, '1, '0), 1'b1, status_word(ST_LARGE, 0));
        add_row(make_cmd(MODE_INSERT, '1, '1, 24'd1000, '0), 1'b1, status_word(ST_OK, 1000));
        add_row(make_cmd(MODE_INSERT, '1, '1, 24'd5, '0), 1'b1,
                status_word(ST_PRESENT, 1000));
        add_row(make_cmd(MODE_LOOKUP, '1, '1, '0, '0), 1'b1, status_word(ST_OK, 1000));
        add_row(make_cmd(MODE_INSERT, 32'd0, 16'd0, 24'd0, '0), 1'b1,
                status_word(ST_OK, 1000));
        add_row(make_cmd(MODE_INSERT, 32'd7, 16'd2, 24'hFF_FFFF, '0), 1'b0, '0);
        add_row(make_cmd(MODE_EXPAND, '0, '0, '0, 24'hFF_FFFF), 1'b0, '0);
        add_row(make_cmd(MODE_INSERT, 32'd7, 16'd2, 24'hFF_FFFF, '0), 1'b0, '0);
        add_row(make_cmd(MODE_DELETE, 32'd0, 16'd0, '0, '0), 1'b0, '0);
        add_row(make_cmd(MODE_REDUCE, '0, '0, '0, 24'd10), 1'b0, '0);
        add_row(make_cmd(MODE_REDUCE, '0, '0, '0, 24'hFF_FFFF), 1'b0, '0);
        add_row(make_cmd(3'd5, '1, '1, '1, '1), 1'b0, '0);
        add_row(make_cmd(3'd7, '0, '0, '0, '0), 1'b0, '0);
        add_row(make_cmd(MODE_REDUCE, '0, '0, '0, 24'hFF_FFFF), 1'b0, '0);
        add_row(make_cmd(MODE_INSERT, 32'd1, 16'd1, 24'd0, '0), 1'b0, '0);
        add_row(make_cmd(MODE_INSERT, 32'd1, 16'd2, 24'd1, '0), 1'b0, '0);
        for (int i = 0; i < dir_rows.size(); i++)
        begin
            send_command(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
            random_gap();
        end

        // full capacity with zero-size entries fills every slot
        write_capacity(32'hFFFF_FFFF);
        for (int i = 0; i < SLOTS + 3; i++)
            send_command(make_cmd(MODE_INSERT, 32'(100 + i), 16'(i), 24'd0, '0),
                         1'b0, '0);

        // random phases over several capacity settings
        caps[0] = 32'd0;
        caps[1] = 32'd120;
        caps[2] = 32'hFFFF_FFFF;
        caps[3] = 32'd60;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_capacity(caps[ph]);
            for (int i = 0; i < 52; i++)
            begin
                send_command(random_cmd(ph), 1'b0, '0);
                if ($urandom_range(0, 3) != 0)
                    random_gap();
            end
        end

        drain();
        $display("%0d commands sent, %0d words checked, %0d of them evictions",
                 cmds_sent, words_seen, evictions_seen);
        $display("insert, lookup, delete, expand, reduce and undefined modes over 5 capacities");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
design/fscs_pkg.sv
design/fscs_search.sv
design/fifo_sized_cache_segment.sv
dv/fifo_sized_cache_segment_tb.sv
